### sv/rthsv_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rthsv_pkg
// Widths and the stage payload type shared by the rgb to hsv pipeline.
// ---------------------------------------------------------------------------
package rthsv_pkg;

    localparam int CHAN_W    = 8;   // one colour channel
    localparam int PIXEL_W   = 3 * CHAN_W;
    localparam int SECTOR_W  = 11;  // hue numerator before scaling, 0..1529
    localparam int SAT_NUM_W = 16;  // 255 * delta
    localparam int SAT_DEN_W = 8;   // max
    localparam int HUE_NUM_W = 19;  // 255 * n
    localparam int HUE_DEN_W = 11;  // 6 * delta
    localparam int QUOT_W    = 8;   // both quotients fit a byte

    // operands handed from the front end to the dividers
    typedef struct packed {
        logic [CHAN_W-1:0]    value;
        logic [SAT_NUM_W-1:0] sat_num;
        logic [SAT_DEN_W-1:0] sat_den;
        logic [HUE_NUM_W-1:0] hue_num;
        logic [HUE_DEN_W-1:0] hue_den;
    } prep_t;

endpackage

### sv/rthsv_prep.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rthsv_prep
// Two-stage front end: max, min, delta and hue sector, then the scaled
// numerators and denominators for the saturation and hue dividers.
// ---------------------------------------------------------------------------
module rthsv_prep
    import rthsv_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [PIXEL_W-1:0] in_pixel,
    output logic               out_valid,
    input  logic               out_ready,
    output prep_t              out_data
);

    logic [CHAN_W-1:0]   r, g, b;
    logic [CHAN_W-1:0]   hi, lo, delta;
    logic [SECTOR_W-1:0] d2, d4, d6;
    logic                red_max, green_max;

    logic                vld_a_reg;
    logic [SECTOR_W-1:0] n_reg, n_next;
    logic [CHAN_W-1:0]   delta_reg;
    logic [CHAN_W-1:0]   hi_reg;

    logic                vld_b_reg;
    prep_t               data_reg, data_next;
    logic [SECTOR_W-1:0] d6_b;

    logic                rdy_a, rdy_b;

    assign rdy_b    = !vld_b_reg || out_ready;
    assign rdy_a    = !vld_a_reg || rdy_b;
    assign in_ready = rdy_a;

    // stage a: range and sector
    assign r = in_pixel[3*CHAN_W-1:2*CHAN_W];
    assign g = in_pixel[2*CHAN_W-1:CHAN_W];
    assign b = in_pixel[CHAN_W-1:0];

    always_comb begin
        hi = (r > g) ? r : g;
        hi = (hi > b) ? hi : b;
        lo = (r < g) ? r : g;
        lo = (lo < b) ? lo : b;
    end

    assign delta     = hi - lo;
    assign red_max   = (r >= g) && (r >= b);
    // only reached when red is not the maximum
    assign green_max = (g >= b);
    assign d2        = SECTOR_W'(delta) << 1;
    assign d4        = SECTOR_W'(delta) << 2;
    assign d6        = d4 + d2;

    always_comb begin
        if (red_max) begin
            // only this sector can go negative, wrap by one full turn
            if (g >= b) begin
                n_next = SECTOR_W'(g - b);
            end else begin
                n_next = d6 - SECTOR_W'(b - g);
            end
        end else if (green_max) begin
            n_next = d2 + SECTOR_W'(b) - SECTOR_W'(r);
        end else begin
            n_next = d4 + SECTOR_W'(r) - SECTOR_W'(g);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_a_reg <= 1'b0;
        end else if (rdy_a) begin
            vld_a_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_a && in_valid) begin
            n_reg     <= n_next;
            delta_reg <= delta;
            hi_reg    <= hi;
        end
    end

    // stage b: times 255 as shift and subtract; zero denominators become one
    // so a grey pixel divides 0 by 1
    assign d6_b = (SECTOR_W'(delta_reg) << 2) + (SECTOR_W'(delta_reg) << 1);

    always_comb begin
        data_next.value   = hi_reg;
        data_next.sat_num = (SAT_NUM_W'(delta_reg) << CHAN_W) - SAT_NUM_W'(delta_reg);
        data_next.sat_den = (hi_reg == '0) ? SAT_DEN_W'(1) : SAT_DEN_W'(hi_reg);
        data_next.hue_num = (HUE_NUM_W'(n_reg) << CHAN_W) - HUE_NUM_W'(n_reg);
        data_next.hue_den = (delta_reg == '0) ? HUE_DEN_W'(1) : HUE_DEN_W'(d6_b);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_b_reg <= 1'b0;
        end else if (rdy_b) begin
            vld_b_reg <= vld_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy_b && vld_a_reg) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = vld_b_reg;
    assign out_data  = data_reg;

endmodule

### sv/rthsv_divider.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rthsv_divider
// Pipelined restoring divider, one quotient bit per stage, with a sideband
// that travels alongside. The numerator must be below den * 2**Q_W.
// ---------------------------------------------------------------------------
module rthsv_divider #(
    parameter int NUM_W  = 16,
    parameter int DEN_W  = 8,
    parameter int Q_W    = 8,   // at least 2
    parameter int SIDE_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [Q_W-1:0]    out_quot,
    output logic [SIDE_W-1:0] out_side
);

    localparam int W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [W-1:0]      rem_v  [Q_W];
    logic [DEN_W-1:0]  den_v  [Q_W];
    logic [Q_W-1:0]    quot_v [Q_W+1];
    logic [SIDE_W-1:0] side_v [Q_W+1];
    logic              vld_v  [Q_W+1];
    logic              rdy_v  [Q_W+1];

    assign rem_v[0]    = W'(in_num);
    assign den_v[0]    = in_den;
    assign quot_v[0]   = '0;
    assign side_v[0]   = in_side;
    assign vld_v[0]    = in_valid;
    assign rdy_v[Q_W]  = out_ready;
    assign in_ready    = rdy_v[0];

    genvar k;
    generate
        for (k = 0; k < Q_W; k++) begin : g_stage
            localparam int BIT = Q_W - 1 - k;

            logic              vld_reg;
            logic [Q_W-1:0]    quot_reg, quot_next;
            logic [SIDE_W-1:0] side_reg;
            logic [W-1:0]      trial;
            logic              fits;

            assign trial     = W'(den_v[k]) << BIT;
            assign fits      = (rem_v[k] >= trial);
            assign quot_next = {quot_v[k][Q_W-2:0], fits};
            assign rdy_v[k]  = !vld_reg || rdy_v[k+1];

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg <= 1'b0;
                end else if (rdy_v[k]) begin
                    vld_reg <= vld_v[k];
                end
            end

            always_ff @(posedge aclk) begin
                if (rdy_v[k] && vld_v[k]) begin
                    quot_reg <= quot_next;
                    side_reg <= side_v[k];
                end
            end

            assign vld_v[k+1]  = vld_reg;
            assign quot_v[k+1] = quot_reg;
            assign side_v[k+1] = side_reg;

            // the last stage needs no remainder
            if (k < Q_W - 1) begin : g_carry
                logic [W-1:0]     rem_reg, rem_next;
                logic [DEN_W-1:0] den_reg;

                assign rem_next = fits ? (rem_v[k] - trial) : rem_v[k];

                always_ff @(posedge aclk) begin
                    if (rdy_v[k] && vld_v[k]) begin
                        rem_reg <= rem_next;
                        den_reg <= den_v[k];
                    end
                end

                assign rem_v[k+1] = rem_reg;
                assign den_v[k+1] = den_reg;
            end
        end
    endgenerate

    assign out_valid = vld_v[Q_W];
    assign out_quot  = quot_v[Q_W];
    assign out_side  = side_v[Q_W];

endmodule

### sv/rgb_to_hsv_converter_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rgb_to_hsv_converter_core
// Streaming 24-bit rgb to 8-bit hue, saturation and value converter.
// ---------------------------------------------------------------------------
// Takes one pixel per clock while the output is not stalled and returns one
// result per pixel, in order: two front-end stages (range, sector, scaling)
// followed by the saturation divider and the hue divider, each a restoring
// divider of 8 stages that settles one quotient bit per stage. Every stage
// has its own valid bit and holds its contents under back-pressure, so empty
// stages are filled while the output waits. Hue is scaled so a full turn
// maps to 255; grey pixels give hue and saturation of zero.
module rgb_to_hsv_converter_core
    import rthsv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // pixel_color[23:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // hue[7:0], saturation[15:8], brightness[23:16]
);

    localparam int SAT_SIDE_W = CHAN_W + HUE_NUM_W + HUE_DEN_W;
    localparam int HUE_SIDE_W = CHAN_W + QUOT_W;

    logic                  prep_valid, prep_ready;
    prep_t                 prep_data;

    logic                  sat_valid, sat_ready;
    logic [QUOT_W-1:0]     sat_quot;
    logic [SAT_SIDE_W-1:0] sat_side;

    logic [QUOT_W-1:0]     hue_quot;
    logic [HUE_SIDE_W-1:0] hue_side;

    rthsv_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_pixel  (s_tdata[PIXEL_W-1:0]),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_data  (prep_data)
    );

    rthsv_divider #(
        .NUM_W  (SAT_NUM_W),
        .DEN_W  (SAT_DEN_W),
        .Q_W    (QUOT_W),
        .SIDE_W (SAT_SIDE_W)
    ) u_sat_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_num    (prep_data.sat_num),
        .in_den    (prep_data.sat_den),
        .in_side   ({prep_data.value, prep_data.hue_num, prep_data.hue_den}),
        .out_valid (sat_valid),
        .out_ready (sat_ready),
        .out_quot  (sat_quot),
        .out_side  (sat_side)
    );

    // hue operands ride through the saturation divider as sideband
    rthsv_divider #(
        .NUM_W  (HUE_NUM_W),
        .DEN_W  (HUE_DEN_W),
        .Q_W    (QUOT_W),
        .SIDE_W (HUE_SIDE_W)
    ) u_hue_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sat_valid),
        .in_ready  (sat_ready),
        .in_num    (sat_side[HUE_NUM_W+HUE_DEN_W-1:HUE_DEN_W]),
        .in_den    (sat_side[HUE_DEN_W-1:0]),
        .in_side   ({sat_side[SAT_SIDE_W-1:HUE_NUM_W+HUE_DEN_W], sat_quot}),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_quot  (hue_quot),
        .out_side  (hue_side)
    );

    assign m_tdata = {hue_side, hue_quot};

    // the input only stalls when every stage is full and the output is held
    a_stall_backed: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a held result");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    // zero saturation only for grey pixels, whose hue is zero too
    a_grey_hue: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[15:8] == 8'd0)) |-> (m_tdata[7:0] == 8'd0))
        else $error("non-zero hue with zero saturation");

    a_black: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[23:16] == 8'd0)) |-> (m_tdata[15:0] == 16'd0))
        else $error("black pixel with non-zero hue or saturation");

    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (sat_valid && sat_ready) |=> (sat_side[HUE_DEN_W-1:0] != '0 || !sat_valid))
        else $error("zero hue denominator reached the hue divider");

endmodule
